@@ design/frl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frl_pkg: shared types and constants of the flash ring log controller
// Field widths, command and action codes, flash layout words, the
// configuration and shared-unit structs, and small helper functions.
// ----------------------------------------------------------------------------
package frl_pkg;

  // ring limits
  localparam int MAX_BLOCKS        = 4096;
  localparam int MAX_ELEMENT_BYTES = 8;

  // field widths
  localparam int ADDR_W    = 28;
  localparam int IDX_W     = 12;
  localparam int BB_W      = 17;
  localparam int EB_W      = 4;
  localparam int SLOT_W    = EB_W + 1;
  localparam int DATA_W    = 64;
  localparam int KIND_W    = 3;
  localparam int ACT_W     = 3;
  localparam int LSO_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MAGIC_W   = 16;

  // remainder unit: one quotient bit per cycle over the full address
  localparam int DIV_STEPS = ADDR_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // request actions
  localparam logic [ACT_W-1:0] ACT_FORMAT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PEEK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DROP   = 3'd4;

  // flash command kinds
  localparam logic [KIND_W-1:0] K_WORD  = 3'd0;
  localparam logic [KIND_W-1:0] K_ELEM  = 3'd1;
  localparam logic [KIND_W-1:0] K_ERASE = 3'd2;
  localparam logic [KIND_W-1:0] K_READ  = 3'd3;
  localparam logic [KIND_W-1:0] K_NONE  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BLOCK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_BLOCK   = 2'd3;

  // configuration reset values
  localparam logic [BB_W-1:0]  RST_BLOCK_BYTES   = 17'd4096;
  localparam logic [EB_W-1:0]  RST_ELEMENT_BYTES = 4'd8;
  localparam logic [IDX_W-1:0] RST_FIRST_BLOCK   = 12'd0;
  localparam logic [IDX_W-1:0] RST_FINAL_BLOCK   = 12'd1;

  // flash layout
  localparam logic [ADDR_W-1:0]  INFO_BYTES    = 28'd12;
  localparam logic [ADDR_W-1:0]  WST_OFFSET    = 28'd4;
  localparam logic [ADDR_W-1:0]  RST_OFFSET    = 28'd8;
  localparam logic [ADDR_W-1:0]  ELEM_OFFSET   = 28'd4;
  localparam logic [SLOT_W-1:0]  SLOT_STATUS   = 5'd4;
  localparam logic [MAGIC_W-1:0] HDR_MAGIC     = 16'hABCD;
  localparam logic [DATA_W-1:0]  ST_UNUSED_BLK = 64'h0000_0000;
  localparam logic [DATA_W-1:0]  ST_CURRENT    = 64'hAAAA_AAAA;
  localparam logic [DATA_W-1:0]  ST_WRITTEN    = 64'hBBBB_BBBB;
  localparam logic [DATA_W-1:0]  ST_READ       = 64'h0000_0000;

  typedef struct packed {
    logic [BB_W-1:0]  block_bytes;
    logic [EB_W-1:0]  element_bytes;
    logic [IDX_W-1:0] first_block;
    logic [IDX_W-1:0] final_block;
  } cfg_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [ADDR_W-1:0] a;
    logic [BB_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] result;    // product (low bits) or remainder
    logic [ADDR_W-1:0] quotient;
  } alu_rsp_t;

  // ring advance: wraps from the final block to the first one
  function automatic logic [IDX_W-1:0] next_block(logic [IDX_W-1:0] idx, cfg_t cfg);
    logic [IDX_W:0] inc;
    inc = {1'b0, idx} + 1'b1;
    if (idx == cfg.final_block) return cfg.first_block;
    return IDX_W'(inc % MAX_BLOCKS);
  endfunction

  function automatic logic [DATA_W-1:0] header_word(logic [EB_W-1:0] eb);
    return {{(DATA_W - MAGIC_W - EB_W){1'b0}}, eb, HDR_MAGIC};
  endfunction

  // byte lanes kept for an element of eb bytes
  function automatic logic [DATA_W-1:0] data_mask(logic [EB_W-1:0] eb);
    logic [EB_W-1:0]   n;
    logic [DATA_W-1:0] m;
    n = (eb > EB_W'(MAX_ELEMENT_BYTES)) ? EB_W'(MAX_ELEMENT_BYTES) : eb;
    for (int i = 0; i < DATA_W / 8; i++) begin
      m[i*8 +: 8] = (i < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

@@ design/frl_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frl_if: request and command channels
// Valid/ready channels; a transaction moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface frl_req_if;
  logic                       valid;
  logic                       ready;
  logic [frl_pkg::ACT_W-1:0]  action;
  logic [frl_pkg::DATA_W-1:0] element_data;

  modport source (output valid, output action, output element_data, input ready);
  modport sink   (input valid, input action, input element_data, output ready);
endinterface

interface frl_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [frl_pkg::KIND_W-1:0] command_kind;
  logic [frl_pkg::ADDR_W-1:0] command_address;
  logic [frl_pkg::DATA_W-1:0] command_value;
  logic                       outcome;
  logic                       run_last;

  modport source (output valid, output command_kind, output command_address,
                  output command_value, output outcome, output run_last, input ready);
  modport sink   (input valid, input command_kind, input command_address,
                  input command_value, input outcome, input run_last, output ready);
endinterface

@@ design/frl_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frl_alu: shared multiply / remainder unit
// Multiply returns the low address bits in the cycle after start. Divide is
// restoring, one quotient bit per cycle; a zero divisor leaves the dividend
// as the remainder.
// ----------------------------------------------------------------------------
module frl_alu (
  input  logic              clk,
  input  logic              rst,
  input  frl_pkg::alu_req_t req,
  output frl_pkg::alu_rsp_t rsp
);

  localparam int AW = frl_pkg::ADDR_W;

  logic                           busy;
  logic                           done;
  logic [frl_pkg::DIV_CNT_W-1:0]  cnt;
  logic [AW-1:0]                  acc;
  logic [AW-1:0]                  quo;
  logic [frl_pkg::BB_W-1:0]       divisor;

  logic [AW:0]   shifted;
  logic [AW:0]   dvs;
  logic [AW:0]   diff;
  logic          ge;
  logic [AW-1:0] acc_step;

  assign shifted  = {acc, quo[AW-1]};
  assign dvs      = {{(AW + 1 - frl_pkg::BB_W){1'b0}}, divisor};
  assign diff     = shifted - dvs;
  assign ge       = (shifted >= dvs);
  assign acc_step = ge ? diff[AW-1:0] : shifted[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.op == frl_pkg::ALU_MUL) begin
          acc  <= AW'(req.a * req.b);
          done <= 1'b1;
        end else begin
          busy    <= 1'b1;
          cnt     <= '0;
          acc     <= '0;
          quo     <= req.a;
          divisor <= req.b;
        end
      end else if (busy) begin
        acc <= acc_step;
        quo <= {quo[AW-2:0], ge};
        if (cnt == frl_pkg::DIV_CNT_W'(frl_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.result   = acc;
  assign rsp.quotient = quo;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("shared unit started while a divide is running");
  a_mul_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (req.start && req.op == frl_pkg::ALU_MUL) |=> (done && !busy))
    else $error("multiply did not finish in one cycle");
`endif

endmodule

@@ design/frl_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frl_seq: request sequencer and ring pointers
// Walks each request through its flash command run, borrowing the shared
// unit for block bases and in-block offsets, and drives the command register.
// ----------------------------------------------------------------------------
module frl_seq (
  input  logic              clk,
  input  logic              rst,
  input  frl_pkg::cfg_t     cfg,
  frl_req_if.sink           req,
  frl_rsp_if.source         rsp,
  output frl_pkg::alu_req_t alu_req,
  input  frl_pkg::alu_rsp_t alu_rsp
);

  localparam int AW = frl_pkg::ADDR_W;
  localparam int IW = frl_pkg::IDX_W;
  localparam int DW = frl_pkg::DATA_W;

  typedef enum logic [26:0] {
    S_IDLE    = 27'h0000001,
    S_F_DIV   = 27'h0000002,
    S_F_MUL   = 27'h0000004,
    S_F_BASE  = 27'h0000008,
    S_F_ERASE = 27'h0000010,
    S_F_HDR   = 27'h0000020,
    S_F_WST   = 27'h0000040,
    S_F_RST   = 27'h0000080,
    S_P_DIV   = 27'h0000100,
    S_P_STAT  = 27'h0000200,
    S_P_ELEM  = 27'h0000400,
    S_P_OBASE = 27'h0000800,
    S_P_CLOSE = 27'h0001000,
    S_P_NBASE = 27'h0002000,
    S_P_ERASE = 27'h0004000,
    S_P_HDR   = 27'h0008000,
    S_P_WST   = 27'h0010000,
    S_P_RBASE = 27'h0020000,
    S_P_RST   = 27'h0040000,
    S_R_READ  = 27'h0080000,
    S_D_DIV   = 27'h0100000,
    S_D_CLR   = 27'h0200000,
    S_D_OBASE = 27'h0400000,
    S_D_RCLR  = 27'h0800000,
    S_D_NBASE = 27'h1000000,
    S_D_RCUR  = 27'h2000000,
    S_NONE    = 27'h4000000
  } state_t;

  state_t state;
  logic   issued;

  // ring pointers
  logic [IW-1:0]                 wblk;
  logic [IW-1:0]                 rblk;
  logic [AW-1:0]                 waddr;
  logic [AW-1:0]                 raddr;
  logic [frl_pkg::LSO_W-1:0]     lso;

  // per-request context
  logic [frl_pkg::ACT_W-1:0]     act;
  logic [DW-1:0]                 data;
  logic                          at_last;
  logic                          none_outcome;

  // command register
  logic                          rsp_valid;
  logic [frl_pkg::KIND_W-1:0]    out_kind;
  logic [AW-1:0]                 out_addr;
  logic [DW-1:0]                 out_value;
  logic                          out_outcome;
  logic                          out_last;

  logic                          emit;
  logic [frl_pkg::KIND_W-1:0]    e_kind;
  logic [AW-1:0]                 e_addr;
  logic [DW-1:0]                 e_value;
  logic                          e_outcome;
  logic                          e_last;
  logic                          can_load;
  logic                          load;

  logic                          compute;
  logic                          step_done;
  logic [frl_pkg::SLOT_W-1:0]    es;
  logic [frl_pkg::BB_W-1:0]      space;
  logic [AW-1:0]                 km1;
  logic [AW-1:0]                 base;
  logic                          rem_last;
  logic                          is_empty;
  logic [IW-1:0]                 wblk_adv;
  logic [IW-1:0]                 rblk_adv;

  assign es       = frl_pkg::SLOT_W'(cfg.element_bytes) + frl_pkg::SLOT_STATUS;
  assign space    = (cfg.block_bytes >= frl_pkg::BB_W'(frl_pkg::INFO_BYTES))
                    ? cfg.block_bytes - frl_pkg::BB_W'(frl_pkg::INFO_BYTES) : '0;
  assign km1      = (alu_rsp.quotient != '0) ? alu_rsp.quotient - AW'(1) : '0;
  assign base     = alu_rsp.result;
  assign rem_last = (alu_rsp.result == AW'(lso));
  assign is_empty = (raddr == waddr);
  assign wblk_adv = frl_pkg::next_block(wblk, cfg);
  assign rblk_adv = frl_pkg::next_block(rblk, cfg);

  assign compute = state inside {S_F_DIV, S_F_MUL, S_F_BASE, S_P_DIV, S_P_OBASE,
                                 S_P_NBASE, S_P_RBASE, S_D_DIV, S_D_OBASE, S_D_NBASE};
  assign step_done = compute && issued && alu_rsp.done;

  // shared unit operands
  always_comb begin
    alu_req.start = compute && !issued;
    alu_req.op    = frl_pkg::ALU_MUL;
    alu_req.a     = '0;
    alu_req.b     = cfg.block_bytes;
    unique case (state) inside
      S_F_DIV: begin
        alu_req.op = frl_pkg::ALU_DIV;
        alu_req.a  = AW'(space);
        alu_req.b  = frl_pkg::BB_W'(es);
      end
      S_F_MUL: begin
        alu_req.a = km1;
        alu_req.b = frl_pkg::BB_W'(es);
      end
      S_F_BASE: begin
        alu_req.a = AW'(cfg.first_block);
      end
      S_P_DIV: begin
        alu_req.op = frl_pkg::ALU_DIV;
        alu_req.a  = waddr;
      end
      S_P_OBASE, S_P_NBASE: begin
        alu_req.a = AW'(wblk);
      end
      S_P_RBASE, S_D_OBASE, S_D_NBASE: begin
        alu_req.a = AW'(rblk);
      end
      S_D_DIV: begin
        alu_req.op = frl_pkg::ALU_DIV;
        alu_req.a  = raddr;
      end
      default: begin
      end
    endcase
  end

  // command of the current state
  always_comb begin
    emit      = 1'b0;
    e_kind    = frl_pkg::K_WORD;
    e_addr    = '0;
    e_value   = '0;
    e_outcome = 1'b0;
    e_last    = 1'b0;
    unique case (state) inside
      S_F_ERASE: begin
        emit   = 1'b1;
        e_kind = frl_pkg::K_ERASE;
        e_addr = AW'(cfg.first_block);
      end
      S_F_HDR, S_P_HDR: begin
        emit    = 1'b1;
        e_addr  = base;
        e_value = frl_pkg::header_word(cfg.element_bytes);
      end
      S_F_WST: begin
        emit    = 1'b1;
        e_addr  = base + frl_pkg::WST_OFFSET;
        e_value = frl_pkg::ST_CURRENT;
      end
      S_F_RST, S_P_RST, S_D_RCUR: begin
        emit    = 1'b1;
        e_addr  = base + frl_pkg::RST_OFFSET;
        e_value = frl_pkg::ST_CURRENT;
        e_last  = 1'b1;
      end
      S_P_STAT: begin
        emit    = 1'b1;
        e_addr  = waddr;
        e_value = frl_pkg::ST_WRITTEN;
      end
      S_P_ELEM: begin
        emit    = 1'b1;
        e_kind  = frl_pkg::K_ELEM;
        e_addr  = waddr + frl_pkg::ELEM_OFFSET;
        e_value = data & frl_pkg::data_mask(cfg.element_bytes);
        e_last  = !at_last;
      end
      S_P_CLOSE: begin
        emit    = 1'b1;
        e_addr  = base + frl_pkg::WST_OFFSET;
        e_value = frl_pkg::ST_UNUSED_BLK;
      end
      S_P_ERASE: begin
        emit   = 1'b1;
        e_kind = frl_pkg::K_ERASE;
        e_addr = AW'(wblk);
      end
      S_P_WST: begin
        emit    = 1'b1;
        e_addr  = base + frl_pkg::WST_OFFSET;
        e_value = frl_pkg::ST_CURRENT;
        e_last  = (wblk != rblk);
      end
      S_R_READ: begin
        emit   = 1'b1;
        e_kind = frl_pkg::K_READ;
        e_addr = raddr + frl_pkg::ELEM_OFFSET;
        e_last = (act == frl_pkg::ACT_PEEK);
      end
      S_D_CLR: begin
        emit    = 1'b1;
        e_addr  = raddr;
        e_value = frl_pkg::ST_READ;
        e_last  = !at_last;
      end
      S_D_RCLR: begin
        emit    = 1'b1;
        e_addr  = base + frl_pkg::RST_OFFSET;
        e_value = frl_pkg::ST_UNUSED_BLK;
      end
      S_NONE: begin
        emit      = 1'b1;
        e_kind    = frl_pkg::K_NONE;
        e_outcome = none_outcome;
        e_last    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign can_load = !rsp_valid || rsp.ready;
  assign load     = emit && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      rsp_valid <= 1'b0;
      wblk      <= '0;
      rblk      <= '0;
      waddr     <= '0;
      raddr     <= '0;
      lso       <= '0;
    end else begin
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      if (compute) begin
        if (!issued) begin
          issued <= 1'b1;
        end else if (alu_rsp.done) begin
          issued <= 1'b0;
        end
      end

      unique case (state) inside
        S_IDLE: begin
          if (req.valid) begin
            act  <= req.action;
            data <= req.element_data;
            unique case (req.action) inside
              frl_pkg::ACT_FORMAT: state <= S_F_DIV;
              frl_pkg::ACT_PUSH:   state <= S_P_DIV;
              frl_pkg::ACT_POP, frl_pkg::ACT_PEEK: begin
                none_outcome <= 1'b1;
                state        <= is_empty ? S_NONE : S_R_READ;
              end
              frl_pkg::ACT_DROP: begin
                none_outcome <= 1'b1;
                state        <= is_empty ? S_NONE : S_D_DIV;
              end
              default: begin
                none_outcome <= 1'b0;
                state        <= S_NONE;
              end
            endcase
          end
        end

        // format: slot count, last slot offset, then the first block
        S_F_DIV: if (step_done) state <= S_F_MUL;
        S_F_MUL: begin
          if (step_done) begin
            lso   <= frl_pkg::LSO_W'(alu_rsp.result) + frl_pkg::LSO_W'(frl_pkg::INFO_BYTES);
            state <= S_F_BASE;
          end
        end
        S_F_BASE:  if (step_done) state <= S_F_ERASE;
        S_F_ERASE: if (load) state <= S_F_HDR;
        S_F_HDR:   if (load) state <= S_F_WST;
        S_F_WST:   if (load) state <= S_F_RST;
        S_F_RST: begin
          if (load) begin
            wblk  <= cfg.first_block;
            rblk  <= cfg.first_block;
            waddr <= base + frl_pkg::INFO_BYTES;
            raddr <= base + frl_pkg::INFO_BYTES;
            state <= S_IDLE;
          end
        end

        // push
        S_P_DIV: begin
          if (step_done) begin
            at_last <= rem_last;
            state   <= S_P_STAT;
          end
        end
        S_P_STAT: if (load) state <= S_P_ELEM;
        S_P_ELEM: begin
          if (load) begin
            if (at_last) begin
              state <= S_P_OBASE;
            end else begin
              waddr <= waddr + AW'(es);
              state <= S_IDLE;
            end
          end
        end
        S_P_OBASE: if (step_done) state <= S_P_CLOSE;
        S_P_CLOSE: begin
          if (load) begin
            wblk  <= wblk_adv;
            state <= S_P_NBASE;
          end
        end
        S_P_NBASE: if (step_done) state <= S_P_ERASE;
        S_P_ERASE: if (load) state <= S_P_HDR;
        S_P_HDR:   if (load) state <= S_P_WST;
        S_P_WST: begin
          if (load) begin
            waddr <= base + frl_pkg::INFO_BYTES;
            if (wblk == rblk) begin
              rblk  <= rblk_adv;
              state <= S_P_RBASE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_P_RBASE: if (step_done) state <= S_P_RST;
        S_P_RST: begin
          if (load) begin
            raddr <= base + frl_pkg::INFO_BYTES;
            state <= S_IDLE;
          end
        end

        // pop / peek read, then drop for pop and drop requests
        S_R_READ: begin
          if (load) begin
            state <= (act == frl_pkg::ACT_PEEK) ? S_IDLE : S_D_DIV;
          end
        end
        S_D_DIV: begin
          if (step_done) begin
            at_last <= rem_last;
            state   <= S_D_CLR;
          end
        end
        S_D_CLR: begin
          if (load) begin
            if (at_last) begin
              state <= S_D_OBASE;
            end else begin
              raddr <= raddr + AW'(es);
              state <= S_IDLE;
            end
          end
        end
        S_D_OBASE: if (step_done) state <= S_D_RCLR;
        S_D_RCLR: begin
          if (load) begin
            rblk  <= rblk_adv;
            state <= S_D_NBASE;
          end
        end
        S_D_NBASE: if (step_done) state <= S_D_RCUR;
        S_D_RCUR: begin
          if (load) begin
            raddr <= base + frl_pkg::INFO_BYTES;
            state <= S_IDLE;
          end
        end

        S_NONE: if (load) state <= S_IDLE;

        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind    <= e_kind;
      out_addr    <= e_addr;
      out_value   <= e_value;
      out_outcome <= e_outcome;
      out_last    <= e_last;
    end
  end

  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = rsp_valid;
  assign rsp.command_kind    = out_kind;
  assign rsp.command_address = out_addr;
  assign rsp.command_value   = out_value;
  assign rsp.outcome         = out_outcome;
  assign rsp.run_last        = out_last;

`ifndef SYNTHESIS
  a_done_issued: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> issued)
    else $error("shared unit result with no request outstanding");
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second request taken while one is in flight");
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (load && e_last) |=> (state == S_IDLE))
    else $error("run continued after its final command");
  a_none_item: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.command_kind == frl_pkg::K_NONE)) |->
      (rsp.run_last && (rsp.command_address == '0) && (rsp.command_value == '0)))
    else $error("no-command item is not a lone cleared item");
`endif

endmodule

@@ design/flash_ring_log_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_ring_log_controller: circular element log over flash erase blocks
// Holds the ring pointers and configuration, and turns each request into a
// run of flash command transactions.
// ----------------------------------------------------------------------------
// Usage: write the four configuration registers while the block is idle, then
// issue a format request before relying on the pointers. Each request on req
// produces one to seven command transactions on rsp, the last flagged by
// run_last; an empty ring on pop, peek or drop, and an unknown action, give a
// single no-command item. One request is handled at a time: req.ready is high
// only between runs, though the final command of a run may still sit in the
// output register while the next request is taken. A peek, an empty or an
// unknown request uses no shared-unit step; every push, pop, drop and format
// computes an in-block offset or a slot count on the shared remainder unit,
// which resolves one bit per cycle over the 28-bit address; rsp back-pressure
// can stall any run. Block bases are products of block index and block size
// on the same shared unit.
// ----------------------------------------------------------------------------
module flash_ring_log_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [frl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frl_pkg::BB_W-1:0]      cfg_data,
  frl_req_if.sink                       req,
  frl_rsp_if.source                     rsp
);

  // configuration registers
  logic [frl_pkg::BB_W-1:0]  block_bytes;
  logic [frl_pkg::EB_W-1:0]  element_bytes;
  logic [frl_pkg::IDX_W-1:0] first_block;
  logic [frl_pkg::IDX_W-1:0] final_block;

  frl_pkg::cfg_t     cfg;
  frl_pkg::alu_req_t alu_req;
  frl_pkg::alu_rsp_t alu_rsp;

  // writes must land only between runs (the user's duty, not enforced here), so no staging is needed
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes   <= frl_pkg::RST_BLOCK_BYTES;
      element_bytes <= frl_pkg::RST_ELEMENT_BYTES;
      first_block   <= frl_pkg::RST_FIRST_BLOCK;
      final_block   <= frl_pkg::RST_FINAL_BLOCK;
    end else if (cfg_write) begin
      unique case (cfg_index)
        frl_pkg::CFG_BLOCK_BYTES:   block_bytes   <= cfg_data;
        frl_pkg::CFG_ELEMENT_BYTES: element_bytes <= cfg_data[frl_pkg::EB_W-1:0];
        frl_pkg::CFG_FIRST_BLOCK:   first_block   <= cfg_data[frl_pkg::IDX_W-1:0];
        frl_pkg::CFG_FINAL_BLOCK:   final_block   <= cfg_data[frl_pkg::IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.block_bytes   = block_bytes;
  assign cfg.element_bytes = element_bytes;
  assign cfg.first_block   = first_block;
  assign cfg.final_block   = final_block;

  // sequencer: pointer state, command runs and the output register
  frl_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .req     (req),
    .rsp     (rsp),
    .alu_req (alu_req),
    .alu_rsp (alu_rsp)
  );

  // shared multiply / remainder unit
  frl_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

endmodule
